// ----- rtl/core/jsce_pkg.sv -----
// ----------------------------------------------------------------------------
// jsce_pkg
// shared types and constants for the jtag shift command engine
// ----------------------------------------------------------------------------
package jsce_pkg;

  localparam logic [7:0] OP_WR_BYTES  = 8'h19;
  localparam logic [7:0] OP_RW_BYTES  = 8'h39;
  localparam logic [7:0] OP_RW_BITS   = 8'h3b;
  localparam logic [7:0] OP_WR_TMS    = 8'h4b;
  localparam logic [7:0] OP_RW_TMS    = 8'h6b;
  localparam logic [7:0] OP_SET_LOW   = 8'h80;
  localparam logic [7:0] OP_READ_LOW  = 8'h81;
  localparam logic [7:0] OP_SET_HIGH  = 8'h82;
  localparam logic [7:0] OP_READ_HIGH = 8'h83;
  localparam logic [7:0] OP_LOOP_OFF  = 8'h85;
  localparam logic [7:0] OP_SET_DIV   = 8'h86;
  localparam logic [7:0] OP_DIV5_OFF  = 8'h8a;
  localparam logic [7:0] OP_DIV5_ON   = 8'h8b;
  localparam logic [7:0] OP_ADAPT_OFF = 8'h97;
  localparam logic [7:0] OP_CLK_HIGH  = 8'h9c;
  localparam logic [7:0] OP_CLK_LOW   = 8'h9d;
  localparam logic [7:0] RESP_BAD     = 8'hfa;
  localparam logic [7:0] POWERED_BIT  = 8'h20;
  localparam logic [7:0] HIGH_READ_BITS = 8'h0c;

  localparam logic [2:0] KIND_RESP  = 3'd0;
  localparam logic [2:0] KIND_LOW   = 3'd1;
  localparam logic [2:0] KIND_HIGH  = 3'd2;
  localparam logic [2:0] KIND_BIT   = 3'd3;
  localparam logic [2:0] KIND_CLOCK = 3'd4;
  localparam logic [2:0] KIND_REJECT = 3'd5;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  direction_byte;
    logic        shift_line;
    logic        bit_value;
    logic [15:0] clock_divisor;
    logic        divide_by_five;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ----- rtl/core/jtag_shift_command_engine_top.sv -----
// ----------------------------------------------------------------------------
// jtag_shift_command_engine_top
// host command parser with one-bit jtag shifter and result queue
// ----------------------------------------------------------------------------
// path: each result is written into the queue, then into the output register
// throughput: one word per cycle while the four-entry queue has room for two
// results; output register stage drains one result per cycle unless stalled
// reset: synchronous, parser idle, divisor zero, divide-by-five set, queue empty
module jtag_shift_command_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  host_byte,
  input  logic        sampled_bit,
  input  logic [4:0]  low_pin_levels,
  input  logic        reset_pin_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  direction_byte,
  output logic        shift_line,
  output logic        bit_value,
  output logic [15:0] clock_divisor,
  output logic        divide_by_five,
  output logic        last
);

  jsce_pkg::push_t   push;
  jsce_pkg::result_t head, res;
  logic              space, nonempty, pop;

  jsce_front u_front (
    .clk(clk), .rst(rst), .accept(in_valid && in_ready),
    .opcode(opcode), .host_byte(host_byte), .sampled_bit(sampled_bit),
    .low_pin_levels(low_pin_levels), .reset_pin_level(reset_pin_level),
    .push(push)
  );

  jsce_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .space(space),
    .pop(pop), .nonempty(nonempty), .head(head)
  );

  jsce_back u_back (
    .clk(clk), .rst(rst), .nonempty(nonempty), .head(head), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .res(res)
  );

  assign in_ready       = space;
  assign kind           = res.kind;
  assign data_byte      = res.data_byte;
  assign direction_byte = res.direction_byte;
  assign shift_line     = res.shift_line;
  assign bit_value      = res.bit_value;
  assign clock_divisor  = res.clock_divisor;
  assign divide_by_five = res.divide_by_five;
  assign last           = res.last;

endmodule

// ----- rtl/core/jsce_front.sv -----
// ----------------------------------------------------------------------------
// jsce_front
// command parser and one-bit shifter, produces up to two results per word
// ----------------------------------------------------------------------------
module jsce_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              opcode,
  input  logic [7:0]        host_byte,
  input  logic              sampled_bit,
  input  logic [4:0]        low_pin_levels,
  input  logic              reset_pin_level,
  output jsce_pkg::push_t   push
);

  typedef enum logic [1:0] {PH_IDLE, PH_ARGS, PH_DATA, PH_SHIFT} phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  cmd, cmd_next;
  logic        argi, argi_next;
  logic [7:0]  farg, farg_next;
  logic [16:0] bcl, bcl_next;
  logic [3:0]  bits, bits_next;
  logic [7:0]  osh, osh_next;
  logic [7:0]  csh, csh_next;
  logic [15:0] div, div_next;
  logic        slow, slow_next;

  logic        reading, bytecmd, clkonly, tms, nrst;
  logic [1:0]  n;
  jsce_pkg::result_t r0, r1;

  always_comb begin
    reading = (cmd == jsce_pkg::OP_RW_BYTES) || (cmd == jsce_pkg::OP_RW_BITS) ||
              (cmd == jsce_pkg::OP_RW_TMS);
    bytecmd = (cmd == jsce_pkg::OP_WR_BYTES) || (cmd == jsce_pkg::OP_RW_BYTES);
    clkonly = (cmd == jsce_pkg::OP_CLK_HIGH) || (cmd == jsce_pkg::OP_CLK_LOW);
    tms     = (cmd == jsce_pkg::OP_WR_TMS) || (cmd == jsce_pkg::OP_RW_TMS);
    nrst    = ~reset_pin_level;
    phase_next = phase;
    cmd_next = cmd;
    argi_next = argi;
    farg_next = farg;
    bcl_next = bcl;
    bits_next = bits;
    osh_next = osh;
    csh_next = csh;
    div_next = div;
    slow_next = slow;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    if (opcode) begin
      if (phase == PH_SHIFT) begin
        osh_next = {1'b0, osh[7:1]};
        if (reading) csh_next = {sampled_bit, csh[7:1]};
        r0.kind = jsce_pkg::KIND_BIT;
        r0.shift_line = tms;
        r0.bit_value = osh[0];
        n = 2'd1;
        bits_next = (bits != 4'd0) ? bits - 4'd1 : 4'd0;
        if (bits_next == 4'd0) begin
          if (reading) begin
            r1.kind = jsce_pkg::KIND_RESP;
            r1.data_byte = csh_next;
            n = 2'd2;
          end
          bcl_next = (bcl != 17'd0) ? bcl - 17'd1 : 17'd0;
          if (bcl_next == 17'd0) phase_next = PH_IDLE;
          else if (bytecmd) phase_next = PH_DATA;
          else if (clkonly) bits_next = 4'd8;
          else phase_next = PH_IDLE;
        end
      end
    end else begin
      unique case (phase)
        PH_ARGS: begin
          if (!argi) begin
            farg_next = host_byte;
            argi_next = 1'b1;
          end else begin
            argi_next = 1'b0;
            phase_next = PH_IDLE;
            if (cmd == jsce_pkg::OP_SET_LOW || cmd == jsce_pkg::OP_SET_HIGH) begin
              r0.kind = (cmd == jsce_pkg::OP_SET_LOW) ? jsce_pkg::KIND_LOW
                                                      : jsce_pkg::KIND_HIGH;
              r0.data_byte = farg;
              r0.direction_byte = host_byte;
              n = 2'd1;
            end else if (cmd == jsce_pkg::OP_SET_DIV) begin
              div_next = {host_byte, farg};
              r0.kind = jsce_pkg::KIND_CLOCK;
              n = 2'd1;
            end else if (bytecmd) begin
              bcl_next = {1'b0, host_byte, farg} + 17'd1;
              phase_next = PH_DATA;
            end else if (clkonly) begin
              bcl_next = {1'b0, host_byte, farg} + 17'd1;
              bits_next = 4'd8;
              osh_next = 8'd0;
              phase_next = PH_SHIFT;
            end else begin
              bits_next = {1'b0, farg[2:0]} + 4'd1;
              osh_next = host_byte;
              csh_next = 8'd0;
              bcl_next = 17'd1;
              phase_next = PH_SHIFT;
              if (tms) begin
                r0.kind = jsce_pkg::KIND_BIT;
                r0.bit_value = host_byte[7];
                n = 2'd1;
              end
            end
          end
        end
        PH_DATA: begin
          osh_next = host_byte;
          bits_next = 4'd8;
          phase_next = PH_SHIFT;
        end
        PH_SHIFT: begin
          r0.kind = jsce_pkg::KIND_REJECT;
          r0.data_byte = host_byte;
          n = 2'd1;
        end
        PH_IDLE: begin
          priority case (host_byte)
            jsce_pkg::OP_SET_LOW, jsce_pkg::OP_SET_HIGH, jsce_pkg::OP_SET_DIV,
            jsce_pkg::OP_WR_BYTES, jsce_pkg::OP_RW_BYTES, jsce_pkg::OP_RW_BITS,
            jsce_pkg::OP_WR_TMS, jsce_pkg::OP_RW_TMS, jsce_pkg::OP_CLK_HIGH,
            jsce_pkg::OP_CLK_LOW: begin
              cmd_next = host_byte;
              argi_next = 1'b0;
              phase_next = PH_ARGS;
            end
            jsce_pkg::OP_READ_LOW: begin
              r0.kind = jsce_pkg::KIND_RESP;
              r0.data_byte = {1'b0, nrst, 1'b1, low_pin_levels};
              n = 2'd1;
            end
            jsce_pkg::OP_READ_HIGH: begin
              r0.kind = jsce_pkg::KIND_RESP;
              r0.data_byte = jsce_pkg::HIGH_READ_BITS | {6'd0, nrst, 1'b0};
              n = 2'd1;
            end
            jsce_pkg::OP_LOOP_OFF, jsce_pkg::OP_ADAPT_OFF: begin
            end
            jsce_pkg::OP_DIV5_OFF, jsce_pkg::OP_DIV5_ON: begin
              slow_next = host_byte[0];
              r0.kind = jsce_pkg::KIND_CLOCK;
              n = 2'd1;
            end
            default: begin
              r0.kind = jsce_pkg::KIND_RESP;
              r0.data_byte = jsce_pkg::RESP_BAD;
              r1.kind = jsce_pkg::KIND_RESP;
              r1.data_byte = host_byte;
              n = 2'd2;
            end
          endcase
        end
        default: phase_next = PH_IDLE;
      endcase
    end
    r0.clock_divisor = div_next;
    r1.clock_divisor = div_next;
    r0.divide_by_five = slow_next;
    r1.divide_by_five = slow_next;
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
    push.count = accept ? n : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cmd <= '0;
      argi <= 1'b0;
      farg <= '0;
      bcl <= '0;
      bits <= '0;
      osh <= '0;
      csh <= '0;
      div <= '0;
      slow <= 1'b1;
    end else if (accept) begin
      phase <= phase_next;
      cmd <= cmd_next;
      argi <= argi_next;
      farg <= farg_next;
      bcl <= bcl_next;
      bits <= bits_next;
      osh <= osh_next;
      csh <= csh_next;
      div <= div_next;
      slow <= slow_next;
    end
  end

  a_bits_range: assert property (@(posedge clk) disable iff (rst) bits <= 4'd8)
    else $error("bit counter out of range");
  a_shift_work: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SHIFT) |-> (bits != 4'd0))
    else $error("shifting with no bits left");
  a_no_push_idle: assert property (@(posedge clk) !accept |-> (push.count == 2'd0))
    else $error("push without accepted word");

endmodule

// ----- rtl/core/jsce_queue.sv -----
// ----------------------------------------------------------------------------
// jsce_queue
// small result queue, takes up to two results and gives one per cycle on pop
// ----------------------------------------------------------------------------
module jsce_queue (
  input  logic               clk,
  input  logic               rst,
  input  jsce_pkg::push_t    push,
  output logic               space,
  input  logic               pop,
  output logic               nonempty,
  output jsce_pkg::result_t  head
);

  jsce_pkg::result_t mem [jsce_pkg::QDEPTH];
  logic [jsce_pkg::QAW-1:0] wp, rp;
  logic [jsce_pkg::QAW:0]   cnt;
  logic                     do_pop;

  assign space    = cnt <= (jsce_pkg::QAW+1)'(jsce_pkg::QDEPTH - 2);
  assign nonempty = cnt != '0;
  assign head     = mem[rp];
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wp] <= push.r0;
    if (push.count == 2'd2) mem[wp + jsce_pkg::QAW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      wp <= wp + jsce_pkg::QAW'(push.count);
      if (do_pop) rp <= rp + jsce_pkg::QAW'(1);
      cnt <= cnt + (jsce_pkg::QAW+1)'(push.count) - (jsce_pkg::QAW+1)'(do_pop);
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= (jsce_pkg::QAW+1)'(jsce_pkg::QDEPTH))
    else $error("queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> space)
    else $error("push into full queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (cnt == $past(cnt) + (jsce_pkg::QAW+1)'($past(push.count))
                          - (jsce_pkg::QAW+1)'($past(do_pop))))
    else $error("queue count mismatch");

endmodule

// ----- rtl/core/jsce_back.sv -----
// ----------------------------------------------------------------------------
// jsce_back
// output register stage, drains the result queue one word per unstalled cycle
// ----------------------------------------------------------------------------
module jsce_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               nonempty,
  input  jsce_pkg::result_t  head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output jsce_pkg::result_t  res
);

  assign pop = nonempty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res <= head;
  end

endmodule
